/* hdl/lkv_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;
    localparam int CFG_W               = 5;
    localparam int KEY_W               = 32;
    localparam int VAL_W               = 32;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // Operation that the controller asks of the datapath in one cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEARCH,
        OP_UPDATE,
        OP_COMMIT
    } lkv_op_t;

    typedef struct packed {
        logic scan_done;
        logic need_update;
        logic out_busy;
    } lkv_status_t;

endpackage

/* hdl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
// A get hit or any put scans the entry memories twice, for the search and the rank update;
// a get miss scans them once. Each scan reads the entry memories one entry per cycle.
// Throughput: one request at a time; the next is accepted the cycle after the result is
// registered, and the result register lets it be accepted while the result waits.
// Reset clears all valid bits and the fill count at once; capacity returns to 16.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [lkv_pkg::CFG_W-1:0]         entries_in_use,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                              evicted,
    output logic signed [lkv_pkg::KEY_W-1:0]  evicted_key
);
    import lkv_pkg::*;

    lkv_op_t     op;
    lkv_status_t status;

    lkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    lkv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .status           (status),
        .cfg_write_enable (cfg_write_enable),
        .entries_in_use   (entries_in_use),
        .mode             (mode),
        .lookup_key       (lookup_key),
        .write_value      (write_value),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .hit              (hit),
        .read_value       (read_value),
        .evicted          (evicted),
        .evicted_key      (evicted_key)
    );

endmodule

/* hdl/lkv_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences the search, rank update and commit of a request.
module lkv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lkv_pkg::lkv_status_t status,
    output lkv_pkg::lkv_op_t    op
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_UPDATE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                op = OP_SEARCH;
                if (status.scan_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // A get miss leaves every rank as it is.
                state_next = status.need_update ? ST_UPDATE : ST_COMMIT;
            end
            ST_UPDATE:
            begin
                op = OP_UPDATE;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    op         = OP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SEARCH))
        else $error("accepted request did not start a search");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_COMMIT) |-> !status.out_busy)
        else $error("commit issued while the result register is held");

endmodule

/* hdl/lkv_datapath.sv */
`timescale 1ns / 1ps
// Datapath: entry memories, valid bits, scan pipeline, search trackers and result register.
module lkv_datapath #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkv_pkg::lkv_op_t                  op,
    output lkv_pkg::lkv_status_t              status,
    input  logic                              cfg_write_enable,
    input  logic [lkv_pkg::CFG_W-1:0]         entries_in_use,
    input  logic                              mode,
    input  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  write_value,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                              evicted,
    output logic signed [lkv_pkg::KEY_W-1:0]  evicted_key
);
    import lkv_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Entry storage.
    logic signed [KEY_W-1:0]  key_mem  [MAX_ENTRIES];
    logic signed [VAL_W-1:0]  val_mem  [MAX_ENTRIES];
    logic        [RANK_W-1:0] rank_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CFG_W-1:0]         cap_reg;

    // Captured request.
    logic                     req_mode_reg;
    logic signed [KEY_W-1:0]  req_key_reg;
    logic signed [VAL_W-1:0]  req_val_reg;

    // Scan pipeline.
    logic [CNT_W-1:0]         addr_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic signed [KEY_W-1:0]  key_rd_reg;
    logic signed [VAL_W-1:0]  val_rd_reg;
    logic [RANK_W-1:0]        rank_rd_reg;
    logic                     vld_rd_reg;

    // Search trackers.
    logic                     found_reg;
    logic [IDX_W-1:0]         found_idx_reg;
    logic signed [VAL_W-1:0]  found_val_reg;
    logic [RANK_W-1:0]        found_rank_reg;
    logic                     lru_have_reg;
    logic [IDX_W-1:0]         lru_idx_reg;
    logic signed [KEY_W-1:0]  lru_key_reg;
    logic                     free_have_reg;
    logic [IDX_W-1:0]         free_idx_reg;

    // Result register.
    logic                     out_valid_reg;
    logic                     hit_reg;
    logic signed [VAL_W-1:0]  read_value_reg;
    logic                     evicted_reg;
    logic signed [KEY_W-1:0]  evicted_key_reg;

    logic             scanning;
    logic             scan_done;
    logic             issue;
    logic [IDX_W-1:0] addr_idx;
    logic             search_step;
    logic             key_match;
    logic             lru_match;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] cap_eff;
    logic             evict;
    logic             insert;
    logic             commit;
    logic [IDX_W-1:0] commit_slot;
    logic             rank_inc;
    logic             rank_we;
    logic [IDX_W-1:0] rank_waddr;
    logic [RANK_W-1:0] rank_wdata;
    logic             val_we;
    logic             key_we;

    assign scanning  = (op == OP_SEARCH) || (op == OP_UPDATE);
    assign scan_done = rd_vld_reg && (rd_idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign issue     = scanning && !scan_done && (addr_reg < CNT_W'(MAX_ENTRIES));
    assign addr_idx  = addr_reg[IDX_W-1:0];

    // Capacity of zero acts as one; anything above the storage depth acts as the depth.
    assign cap_ext = CMP_W'(cap_reg);
    assign max_ext = CMP_W'(MAX_ENTRIES);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > max_ext)
        begin
            cap_eff = max_ext;
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign evict  = (CMP_W'(count_reg) >= cap_eff) && (count_reg != '0) && lru_have_reg;
    assign insert = !found_reg && req_mode_reg && (evict || free_have_reg);
    assign commit = (op == OP_COMMIT);
    assign commit_slot = found_reg ? found_idx_reg : (evict ? lru_idx_reg : free_idx_reg);

    assign search_step = (op == OP_SEARCH) && rd_vld_reg;
    assign key_match   = vld_rd_reg && (key_rd_reg == req_key_reg);
    assign lru_match   = vld_rd_reg && (CNT_W'(rank_rd_reg) == (count_reg - CNT_W'(1)));

    // On a hit only entries more recent than the hit entry age; on an insert all valid ones do.
    assign rank_inc = (op == OP_UPDATE) && rd_vld_reg && vld_rd_reg &&
                      (found_reg ? (rank_rd_reg < found_rank_reg) : 1'b1);
    assign rank_we    = rank_inc || (commit && (found_reg || insert));
    assign rank_waddr = commit ? commit_slot : rd_idx_reg;
    assign rank_wdata = commit ? '0 : (rank_rd_reg + RANK_W'(1));
    assign val_we     = commit && ((found_reg && req_mode_reg) || insert);
    assign key_we     = commit && insert;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (op == OP_LOAD)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (scanning)
        begin
            if (scan_done)
            begin
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (issue)
            begin
                addr_reg   <= addr_reg + CNT_W'(1);
                rd_vld_reg <= 1'b1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            key_rd_reg  <= key_mem[addr_idx];
            val_rd_reg  <= val_mem[addr_idx];
            rank_rd_reg <= rank_mem[addr_idx];
            vld_rd_reg  <= valid_reg[addr_idx];
            rd_idx_reg  <= addr_idx;
        end
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (val_we)
        begin
            val_mem[commit_slot] <= req_val_reg;
        end
        if (key_we)
        begin
            key_mem[commit_slot] <= req_key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
        begin
            req_mode_reg <= mode;
            req_key_reg  <= lookup_key;
            req_val_reg  <= write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            lru_have_reg  <= 1'b0;
            free_have_reg <= 1'b0;
        end
        else if (op == OP_LOAD)
        begin
            found_reg     <= 1'b0;
            lru_have_reg  <= 1'b0;
            free_have_reg <= 1'b0;
        end
        else if (search_step)
        begin
            if (key_match)
            begin
                found_reg <= 1'b1;
            end
            if (lru_match)
            begin
                lru_have_reg <= 1'b1;
            end
            if (!vld_rd_reg)
            begin
                free_have_reg <= 1'b1;
            end
        end
    end

    // The first match in slot order wins, as does the first free slot.
    always_ff @(posedge clk)
    begin
        if (search_step)
        begin
            if (key_match && !found_reg)
            begin
                found_idx_reg  <= rd_idx_reg;
                found_val_reg  <= val_rd_reg;
                found_rank_reg <= rank_rd_reg;
            end
            if (lru_match && !lru_have_reg)
            begin
                lru_idx_reg <= rd_idx_reg;
                lru_key_reg <= key_rd_reg;
            end
            if (!vld_rd_reg && !free_have_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg   <= CAPACITY_RESET;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                cap_reg <= entries_in_use;
            end
            if (commit && insert)
            begin
                valid_reg[commit_slot] <= 1'b1;
                if (!evict)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg         <= found_reg;
            read_value_reg  <= (found_reg && !req_mode_reg) ? found_val_reg : '0;
            evicted_reg     <= insert && evict;
            evicted_key_reg <= (insert && evict) ? lru_key_reg : '0;
        end
    end

    assign status.scan_done   = scan_done;
    assign status.need_update = found_reg || insert;
    assign status.out_busy    = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count disagrees with the valid bits");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count above storage depth");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && evicted_reg) |-> !hit_reg)
        else $error("eviction reported on a hit");

endmodule

/* sim/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key/value cache: directed table, then random phases.
module lru_key_value_cache_tb;

    localparam int SLOTS         = lkv_pkg::MAX_ENTRIES_DEFAULT;
    localparam int KW            = lkv_pkg::KEY_W;
    localparam int VW            = lkv_pkg::VAL_W;
    localparam int CW            = lkv_pkg::CFG_W;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 16;
    localparam int LONG_HOLD     = 250;
    localparam int PHASE_ITEMS   = 45;
    localparam int NUM_PHASES    = 9;
    localparam int POOL_MAX      = 24;
    localparam int NUM_ROWS      = 22;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CAPACITY
    } row_kind_t;

    typedef struct packed {
        logic          hit;
        logic [VW-1:0] read_value;
        logic          evicted;
        logic [KW-1:0] evicted_key;
    } access_result_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [CW-1:0]  capacity;
        logic           op;
        logic [KW-1:0]  key;
        logic [VW-1:0]  value;
        logic           typed;
        access_result_t result;
    } stim_row_t;

    localparam access_result_t NO_HIT = '0;

    // Rows with typed set carry a result that is plain from the request history;
    // the rest are checked against the predictor.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
          access_result_t'{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
          access_result_t'{1'b1, 32'h0, 1'b0, 32'h0}},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
          access_result_t'{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1,
          access_result_t'{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
        '{ROW_CAPACITY, 5'd0,  CMD_GET, 32'h0,         32'h0,         1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h0000_0005, 32'h0000_0037, 1'b1,
          access_result_t'{1'b0, 32'h0, 1'b1, 32'h8000_0000}},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h0000_0006, 32'h0000_0042, 1'b0, NO_HIT},
        '{ROW_CAPACITY, 5'd1,  CMD_GET, 32'h0,         32'h0,         1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h0000_0007, 32'h0000_004D, 1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, NO_HIT},
        '{ROW_CAPACITY, 5'd3,  CMD_GET, 32'h0,         32'h0,         1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_HIT},
        '{ROW_CAPACITY, 5'd16, CMD_GET, 32'h0,         32'h0,         1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_PUT, 32'h0000_0001, 32'h0000_0002, 1'b0, NO_HIT},
        '{ROW_REQUEST,  5'd0,  CMD_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, NO_HIT}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_enable;
    logic [CW-1:0]        cap_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode_in;
    logic signed [KW-1:0] key_in;
    logic signed [VW-1:0] value_in;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit_out;
    logic signed [VW-1:0] read_out;
    logic                 evicted_out;
    logic signed [KW-1:0] evicted_key_out;

    // Shadow copy of the cache contents and recency ranks.
    logic [KW-1:0]  slot_key   [SLOTS];
    logic [VW-1:0]  slot_value [SLOTS];
    logic           slot_live  [SLOTS];
    logic [3:0]     slot_age   [SLOTS];
    int unsigned    live_count;
    logic [CW-1:0]  capacity_reg;

    access_result_t pending_results [$];
    int             fail_count;
    int unsigned    cycle_count;
    bit             quiet;
    bit             hold_off_req;

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .entries_in_use   (cap_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode_in),
        .lookup_key       (key_in),
        .write_value      (value_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit_out),
        .read_value       (read_out),
        .evicted          (evicted_out),
        .evicted_key      (evicted_key_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

    function automatic int unsigned effective_capacity(input logic [CW-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > SLOTS)
            return SLOTS;
        return 32'(cap);
    endfunction

    // Applies one request to the shadow cache and returns what the block should report.
    function automatic access_result_t predict_access(input logic op, input logic [KW-1:0] key,
                                                      input logic [VW-1:0] value);
        access_result_t res;
        int             found;
        int             slot;
        int             i;
        logic [3:0]     rank;
        res   = NO_HIT;
        found = -1;
        slot  = -1;
        for (i = 0; i < SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key)
                found = i;
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (op == CMD_GET)
                res.read_value = slot_value[found];
            else
                slot_value[found] = value;
            rank = slot_age[found];
            for (i = 0; i < SLOTS; i++)
                if (slot_live[i] && slot_age[i] < rank)
                    slot_age[i]++;
            slot_age[found] = 4'd0;
        end
        else if (op == CMD_PUT)
        begin
            if (live_count >= effective_capacity(capacity_reg) && live_count > 0)
            begin
                for (i = 0; i < SLOTS; i++)
                    if (slot < 0 && slot_live[i] && 32'(slot_age[i]) == live_count - 1)
                        slot = i;
                if (slot >= 0)
                begin
                    res.evicted     = 1'b1;
                    res.evicted_key = slot_key[slot];
                    slot_live[slot] = 1'b0;
                    live_count--;
                end
            end
            // Without an eviction the lowest free slot takes the new entry.
            if (slot < 0)
                for (i = 0; i < SLOTS; i++)
                    if (slot < 0 && !slot_live[i])
                        slot = i;
            if (slot >= 0)
            begin
                for (i = 0; i < SLOTS; i++)
                    if (slot_live[i])
                        slot_age[i]++;
                slot_key[slot]   = key;
                slot_value[slot] = value;
                slot_live[slot]  = 1'b1;
                slot_age[slot]   = 4'd0;
                live_count++;
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic op, input logic [KW-1:0] key,
                                input logic [VW-1:0] value, input logic typed,
                                input access_result_t typed_res);
        int             gap;
        access_result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode_in  <= op;
        key_in   <= key;
        value_in <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = predict_access(op, key, value);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] cap);
        wait_all_results();
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cap_wdata        <= cap;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        capacity_reg = cap;
    endtask

    initial
    begin : result_side
        int             gap;
        int             hold_left;
        access_result_t want;
        gap       = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_left    = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (gap > 0)
            begin
                out_stall <= 1'b1;
                gap--;
            end
            else
                out_stall <= 1'b0;
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (hit_out !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, hit_out);
                        fail_count++;
                    end
                    if (read_out !== want.read_value)
                    begin
                        $error("read_value: expected %08h, got %08h", want.read_value, read_out);
                        fail_count++;
                    end
                    if (evicted_out !== want.evicted)
                    begin
                        $error("evicted: expected %0b, got %0b", want.evicted, evicted_out);
                        fail_count++;
                    end
                    if (evicted_key_out !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %08h, got %08h",
                               want.evicted_key, evicted_key_out);
                        fail_count++;
                    end
                end
                gap = quiet ? 0 : $urandom_range(0, 12);
            end
        end
    end

    initial
    begin : stimulus
        logic [CW-1:0] phase_caps [NUM_PHASES];
        logic [KW-1:0] key_pool [POOL_MAX];
        logic [KW-1:0] key;
        logic [VW-1:0] value;
        stim_row_t     row;
        int            r;
        int            phase;
        int            n;
        int            pool_size;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cap_wdata        = '0;
        in_valid         = 1'b0;
        mode_in          = CMD_GET;
        key_in           = '0;
        value_in         = '0;
        quiet            = 1'b0;
        hold_off_req     = 1'b0;
        fail_count       = 0;
        live_count       = 0;
        capacity_reg     = lkv_pkg::CAPACITY_RESET;
        for (r = 0; r < SLOTS; r++)
        begin
            slot_key[r]   = '0;
            slot_value[r] = '0;
            slot_live[r]  = 1'b0;
            slot_age[r]   = '0;
        end
        phase_caps = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd0, 5'd8, 5'd17, 5'd5, 5'd16};
        phase_caps[7] = CW'($urandom_range(3, 15));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CAPACITY)
                write_capacity(row.capacity);
            else
                send_request(row.op, row.key, row.value, row.typed, row.result);
        end

        // Keys come mostly from a pool a little larger than the capacity, so that
        // hits, updates and evictions all happen often.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_capacity(phase_caps[phase]);
            quiet     = (phase == 3);
            pool_size = effective_capacity(phase_caps[phase]) + $urandom_range(1, 6);
            for (n = 0; n < pool_size; n++)
                key_pool[n] = $urandom();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == 3)
                    hold_off_req = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                case ($urandom_range(0, 9))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    2:       value = 32'h7FFF_FFFF;
                    3:       value = 32'h8000_0000;
                    default: value = $urandom();
                endcase
                send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, value, 1'b0, NO_HIT);
            end
        end
        quiet = 1'b0;

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** lru_key_value_cache: PASSED **");
        else
            $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

endmodule

/* lru_key_value_cache.f */
hdl/lkv_pkg.sv
hdl/lkv_ctrl.sv
hdl/lkv_datapath.sv
hdl/lru_key_value_cache.sv
sim/lru_key_value_cache_tb.sv
